[hw/rtl/mips_integer_execute_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the MIPS I integer execute unit
// Define NO_ASSERTIONS to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MIEU_ASSERT_HOLDS(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("mieu: same-cycle check failed");
`define MIEU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("mieu: next-cycle check failed");
`else
`define MIEU_ASSERT_HOLDS(lbl, ck, rn, ante, cons)
`define MIEU_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[hw/rtl/mieu_pkg.sv]
// ----------------------------------------------------------------------------
// mieu_pkg
// Types, codes and opcode constants of the MIPS I integer execute unit.
// ----------------------------------------------------------------------------
package mieu_pkg;

  typedef enum logic [2:0] {
    EXC_NONE       = 3'd0,
    EXC_OVERFLOW   = 3'd1,
    EXC_LOAD_ADDR  = 3'd2,
    EXC_STORE_ADDR = 3'd3,
    EXC_BREAK      = 3'd4,
    EXC_SYSCALL    = 3'd5,
    EXC_RESERVED   = 3'd6,
    EXC_COP        = 3'd7
  } exc_code_t;

  typedef enum logic [2:0] {
    MEM_NONE    = 3'd0,
    MEM_RD_WORD = 3'd1,
    MEM_RD_HALF = 3'd2,
    MEM_RD_BYTE = 3'd3,
    MEM_WR_WORD = 3'd4,
    MEM_WR_HALF = 3'd5,
    MEM_WR_BYTE = 3'd6
  } mem_op_t;

  typedef enum logic [3:0] {
    PK_NONE = 4'd0,
    PK_LB   = 4'd1,
    PK_LBU  = 4'd2,
    PK_LH   = 4'd3,
    PK_LHU  = 4'd4,
    PK_LW   = 4'd5,
    PK_LWL  = 4'd6,
    PK_LWR  = 4'd7,
    PK_SWL  = 4'd8,
    PK_SWR  = 4'd9
  } pend_kind_t;

  typedef enum logic [1:0] {
    MD_MULT  = 2'd0,
    MD_MULTU = 2'd1,
    MD_DIV   = 2'd2,
    MD_DIVU  = 2'd3
  } md_op_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_MDWAIT = 2'd2
  } ieu_state_t;

  typedef enum logic [2:0] {
    MDS_IDLE = 3'd0,
    MDS_MUL  = 3'd1,
    MDS_DIV  = 3'd2,
    MDS_FIX  = 3'd3,
    MDS_DONE = 3'd4
  } md_state_t;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_COP1    = 6'h11;
  localparam logic [5:0] OP_COP2    = 6'h12;
  localparam logic [5:0] OP_COP3    = 6'h13;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2a;
  localparam logic [5:0] OP_SW      = 6'h2b;
  localparam logic [5:0] OP_SWR     = 6'h2e;
  localparam logic [5:0] OP_LWC0    = 6'h30;
  localparam logic [5:0] OP_LWC1    = 6'h31;
  localparam logic [5:0] OP_LWC2    = 6'h32;
  localparam logic [5:0] OP_LWC3    = 6'h33;
  localparam logic [5:0] OP_SWC0    = 6'h38;
  localparam logic [5:0] OP_SWC1    = 6'h39;
  localparam logic [5:0] OP_SWC2    = 6'h3a;
  localparam logic [5:0] OP_SWC3    = 6'h3b;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_BREAK   = 6'h0d;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1a;
  localparam logic [5:0] FN_DIVU    = 6'h1b;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  localparam logic [4:0] LINK_REG   = 5'd31;
  localparam logic [3:0] REGIMM_LINK = 4'b1000;

  typedef struct packed {
    logic        kind;
    logic [31:0] instruction;
    logic [31:0] pc_now;
    logic [31:0] link_pc;
    logic [31:0] mem_data;
  } in_item_t;

  typedef struct packed {
    exc_code_t   exception_code;
    logic        wb_valid;
    logic [4:0]  wb_index;
    logic [31:0] wb_value;
    logic        branch_taken;
    logic [31:0] branch_target;
    mem_op_t     mem_op;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
  } out_item_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic [31:0] hi;
    logic [31:0] lo;
    logic        load_issued;
    logic        delay_active;
    logic [4:0]  delayed_index;
    logic [31:0] delayed_old;
    pend_kind_t  pend_kind;
    logic [4:0]  pend_target;
    logic [31:0] pend_addr;
    logic [31:0] pend_store;
  } arch_t;

  typedef struct packed {
    logic        start;
    md_op_t      op;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_rsp_t;

endpackage

[hw/rtl/mieu_if.sv]
// ----------------------------------------------------------------------------
// mieu_if
// Valid/ready channels of the execute unit: request in, result out.
// ----------------------------------------------------------------------------
interface mieu_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] instruction;
  logic [31:0] pc_now;
  logic [31:0] link_pc;
  logic [31:0] mem_data;

  modport source (output valid, kind, instruction, pc_now, link_pc, mem_data,
                  input ready);
  modport sink (input valid, kind, instruction, pc_now, link_pc, mem_data,
                output ready);
endinterface

interface mieu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  exception_code;
  logic        wb_valid;
  logic [4:0]  wb_index;
  logic [31:0] wb_value;
  logic        branch_taken;
  logic [31:0] branch_target;
  logic [2:0]  mem_op;
  logic [31:0] mem_addr;
  logic [31:0] mem_wdata;

  modport source (output valid, exception_code, wb_valid, wb_index, wb_value,
                  branch_taken, branch_target, mem_op, mem_addr, mem_wdata,
                  input ready);
  modport sink (input valid, exception_code, wb_valid, wb_index, wb_value,
                branch_taken, branch_target, mem_op, mem_addr, mem_wdata,
                output ready);
endinterface

[hw/rtl/mips_integer_execute_unit.sv]
// ----------------------------------------------------------------------------
// mips_integer_execute_unit: MIPS I integer execute with HI/LO and load delay
// IDLE takes a request and registers its file read; EXEC registers the result
// once the output is free; no request is taken until then. MULT/MULTU and
// DIV/DIVU hold the next request until HI/LO are written (one quotient bit a
// cycle); zero divisors skip it. Reset clears the file's valid bits, no sweep.
// ----------------------------------------------------------------------------
`include "mips_integer_execute_unit_assert.svh"

module mips_integer_execute_unit (
  input  logic       clk,
  input  logic       rst_n,
  mieu_in_if.sink    in_ch,
  mieu_out_if.source out_ch
);

  mieu_pkg::ieu_state_t state_r, state_nxt;
  mieu_pkg::in_item_t   in_item_r;
  mieu_pkg::arch_t      arch_r, arch_nxt;
  mieu_pkg::out_item_t  out_item_r, exec_res;
  mieu_pkg::rf_wr_t     exec_wr, rf_wr;
  mieu_pkg::md_req_t    exec_md, md_req;
  mieu_pkg::md_rsp_t    md_rsp;

  logic        out_valid_r;
  logic        accept, out_free, commit;
  logic [4:0]  raddr_a;
  logic [31:0] rdata_a, rdata_b;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign commit   = (state_r == mieu_pkg::ST_EXEC) && out_free;

  // data returns read the pending target, instructions read rs/rt
  assign raddr_a = in_ch.kind ? arch_r.pend_target : in_ch.instruction[25:21];

  mieu_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .raddr_a (raddr_a),
    .raddr_b (in_ch.instruction[20:16]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .wr      (rf_wr)
  );

  mieu_exec u_exec (
    .item     (in_item_r),
    .rd_a     (rdata_a),
    .rd_b     (rdata_b),
    .arch     (arch_r),
    .res      (exec_res),
    .wr       (exec_wr),
    .arch_nxt (arch_nxt),
    .md       (exec_md)
  );

  always_comb begin
    rf_wr       = exec_wr;
    rf_wr.en    = exec_wr.en && commit;
    md_req      = exec_md;
    md_req.start = exec_md.start && commit;
  end

  mieu_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mieu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mieu_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = mieu_pkg::ST_EXEC;
        end
      end
      mieu_pkg::ST_EXEC: begin
        if (commit) begin
          state_nxt = exec_md.start ? mieu_pkg::ST_MDWAIT : mieu_pkg::ST_IDLE;
        end
      end
      mieu_pkg::ST_MDWAIT: begin
        if (md_rsp.done) begin
          state_nxt = mieu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mieu_pkg::ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == mieu_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r.kind        <= in_ch.kind;
      in_item_r.instruction <= in_ch.instruction;
      in_item_r.pc_now      <= in_ch.pc_now;
      in_item_r.link_pc     <= in_ch.link_pc;
      in_item_r.mem_data    <= in_ch.mem_data;
    end
    if (commit) begin
      out_item_r <= exec_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r <= '0;
    end else if (commit) begin
      arch_r <= arch_nxt;
    end else if ((state_r == mieu_pkg::ST_MDWAIT) && md_rsp.done) begin
      arch_r.hi <= md_rsp.hi;
      arch_r.lo <= md_rsp.lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.exception_code = out_item_r.exception_code;
  assign out_ch.wb_valid       = out_item_r.wb_valid;
  assign out_ch.wb_index       = out_item_r.wb_index;
  assign out_ch.wb_value       = out_item_r.wb_value;
  assign out_ch.branch_taken   = out_item_r.branch_taken;
  assign out_ch.branch_target  = out_item_r.branch_target;
  assign out_ch.mem_op         = out_item_r.mem_op;
  assign out_ch.mem_addr       = out_item_r.mem_addr;
  assign out_ch.mem_wdata      = out_item_r.mem_wdata;

  `MIEU_ASSERT_HOLDS(a_no_r0_write, clk, rst_n, rf_wr.en, rf_wr.idx != 5'd0)
  `MIEU_ASSERT_NEXT(a_md_waits, clk, rst_n, md_req.start, state_r == mieu_pkg::ST_MDWAIT)
  `MIEU_ASSERT_HOLDS(a_exc_quiet, clk, rst_n, out_valid_r && out_item_r.exception_code != mieu_pkg::EXC_NONE, !out_item_r.wb_valid && out_item_r.mem_op == mieu_pkg::MEM_NONE)

endmodule

[hw/rtl/mieu_regfile.sv]
// ----------------------------------------------------------------------------
// mieu_regfile
// 32x32 general register file: two registered read ports, one write port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module mieu_regfile (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [4:0]          raddr_a,
  input  logic [4:0]          raddr_b,
  output logic [31:0]         rdata_a,
  output logic [31:0]         rdata_b,
  input  mieu_pkg::rf_wr_t    wr
);

  logic [31:0] mem [32];
  logic [31:0] vld_r;
  logic [31:0] data_a_r, data_b_r;
  logic        hit_a_r, hit_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      data_a_r <= mem[raddr_a];
      data_b_r <= mem[raddr_b];
      hit_a_r  <= vld_r[raddr_a];
      hit_b_r  <= vld_r[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.idx] <= 1'b1;
    end
  end

  assign rdata_a = hit_a_r ? data_a_r : 32'd0;
  assign rdata_b = hit_b_r ? data_b_r : 32'd0;

endmodule

[hw/rtl/mieu_muldiv.sv]
// ----------------------------------------------------------------------------
// mieu_muldiv
// HI/LO multiply and divide unit: a registered 33x33 multiply, and a
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mieu_muldiv (
  input  logic               clk,
  input  logic               rst_n,
  input  mieu_pkg::md_req_t  req,
  output mieu_pkg::md_rsp_t  rsp
);

  mieu_pkg::md_state_t state_r, state_nxt;

  logic signed [32:0] opa_r, opb_r;
  logic signed [65:0] prod;
  logic [31:0]        rem_r, quo_r, dvs_r, hi_r, lo_r;
  logic [4:0]         cnt_r;
  logic               neg_q_r, neg_r_r;
  logic [33:0]        trial;
  logic               is_mul, is_signed;
  logic [31:0]        mag_a, mag_b;

  assign is_mul    = (req.op == mieu_pkg::MD_MULT) || (req.op == mieu_pkg::MD_MULTU);
  assign is_signed = (req.op == mieu_pkg::MD_MULT) || (req.op == mieu_pkg::MD_DIV);
  assign mag_a     = (is_signed && req.a[31]) ? (32'd0 - req.a) : req.a;
  assign mag_b     = (is_signed && req.b[31]) ? (32'd0 - req.b) : req.b;
  assign prod      = opa_r * opb_r;
  assign trial     = {1'b0, rem_r, quo_r[31]} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mieu_pkg::MDS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mieu_pkg::MDS_IDLE: begin
        if (req.start) begin
          if (is_mul) begin
            state_nxt = mieu_pkg::MDS_MUL;
          end else if (req.b == 32'd0) begin
            state_nxt = mieu_pkg::MDS_DONE;
          end else begin
            state_nxt = mieu_pkg::MDS_DIV;
          end
        end
      end
      mieu_pkg::MDS_MUL:  state_nxt = mieu_pkg::MDS_DONE;
      mieu_pkg::MDS_DIV: begin
        if (cnt_r == 5'd0) begin
          state_nxt = mieu_pkg::MDS_FIX;
        end
      end
      mieu_pkg::MDS_FIX:  state_nxt = mieu_pkg::MDS_DONE;
      mieu_pkg::MDS_DONE: state_nxt = mieu_pkg::MDS_IDLE;
      default:            state_nxt = mieu_pkg::MDS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mieu_pkg::MDS_IDLE: begin
        if (req.start) begin
          opa_r   <= {is_signed & req.a[31], req.a};
          opb_r   <= {is_signed & req.b[31], req.b};
          quo_r   <= mag_a;
          dvs_r   <= mag_b;
          rem_r   <= 32'd0;
          cnt_r   <= 5'd31;
          neg_q_r <= is_signed && (req.a[31] ^ req.b[31]);
          neg_r_r <= is_signed && req.a[31];
          // divide by zero: fixed quotient, remainder is the dividend
          lo_r    <= (is_signed && req.a[31]) ? 32'd1 : 32'hffff_ffff;
          hi_r    <= req.a;
        end
      end
      mieu_pkg::MDS_MUL: begin
        hi_r <= prod[63:32];
        lo_r <= prod[31:0];
      end
      mieu_pkg::MDS_DIV: begin
        if (!trial[33]) begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= {rem_r[30:0], quo_r[31]};
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
      end
      mieu_pkg::MDS_FIX: begin
        lo_r <= neg_q_r ? (32'd0 - quo_r) : quo_r;
        hi_r <= neg_r_r ? (32'd0 - rem_r) : rem_r;
      end
      default: ;
    endcase
  end

  assign rsp.done = (state_r == mieu_pkg::MDS_DONE);
  assign rsp.hi   = hi_r;
  assign rsp.lo   = lo_r;

endmodule

[hw/rtl/mieu_exec.sv]
// ----------------------------------------------------------------------------
// mieu_exec
// Decode and execute of one request against the register read data:
// result fields, register write, next architectural state, HI/LO request.
// ----------------------------------------------------------------------------
module mieu_exec (
  input  mieu_pkg::in_item_t  item,
  input  logic [31:0]         rd_a,
  input  logic [31:0]         rd_b,
  input  mieu_pkg::arch_t     arch,
  output mieu_pkg::out_item_t res,
  output mieu_pkg::rf_wr_t    wr,
  output mieu_pkg::arch_t     arch_nxt,
  output mieu_pkg::md_req_t   md
);

  logic [5:0]  opc, fn;
  logic [4:0]  rs, rt, rd, sa, tgt;
  logic [15:0] imm;
  logic [31:0] simm, zimm, a, b, sum, dif, ad, btgt, jtgt;
  logic [31:0] cur, old, d, s, loadv, storev, wval;
  logic [1:0]  sh;
  logic [4:0]  widx;
  logic        wreq;

  assign opc  = item.instruction[31:26];
  assign rs   = item.instruction[25:21];
  assign rt   = item.instruction[20:16];
  assign rd   = item.instruction[15:11];
  assign sa   = item.instruction[10:6];
  assign fn   = item.instruction[5:0];
  assign imm  = item.instruction[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign zimm = {16'd0, imm};

  // operands see the old value of a register whose load is still in its delay slot
  assign a = (arch.load_issued && arch.delayed_index == rs) ? arch.delayed_old : rd_a;
  assign b = (arch.load_issued && arch.delayed_index == rt) ? arch.delayed_old : rd_b;

  assign sum  = a + b;
  assign dif  = a - b;
  assign ad   = a + simm;
  assign btgt = item.pc_now + {simm[29:0], 2'b00};
  assign jtgt = {item.pc_now[31:28], item.instruction[25:0], 2'b00};

  // load completion operands
  assign tgt = arch.pend_target;
  assign cur = rd_a;
  assign old = (arch.delay_active && arch.delayed_index == tgt) ? arch.delayed_old : cur;
  assign d   = item.mem_data;
  assign s   = arch.pend_store;
  assign sh  = arch.pend_addr[1:0];

  always_comb begin
    loadv = d;
    case (arch.pend_kind)
      mieu_pkg::PK_LB:  loadv = {{24{d[7]}}, d[7:0]};
      mieu_pkg::PK_LBU: loadv = {24'd0, d[7:0]};
      mieu_pkg::PK_LH:  loadv = {{16{d[15]}}, d[15:0]};
      mieu_pkg::PK_LHU: loadv = {16'd0, d[15:0]};
      mieu_pkg::PK_LWL: begin
        case (sh)
          2'd0:    loadv = {d[7:0], cur[23:0]};
          2'd1:    loadv = {d[15:0], cur[15:0]};
          2'd2:    loadv = {d[23:0], cur[7:0]};
          default: loadv = d;
        endcase
      end
      mieu_pkg::PK_LWR: begin
        case (sh)
          2'd0:    loadv = d;
          2'd1:    loadv = {cur[31:24], d[31:8]};
          2'd2:    loadv = {cur[31:16], d[31:16]};
          default: loadv = {cur[31:8], d[31:24]};
        endcase
      end
      default: loadv = d;
    endcase
  end

  always_comb begin
    if (arch.pend_kind == mieu_pkg::PK_SWL) begin
      case (sh)
        2'd0:    storev = {d[31:8], s[31:24]};
        2'd1:    storev = {d[31:16], s[31:16]};
        2'd2:    storev = {d[31:24], s[31:8]};
        default: storev = s;
      endcase
    end else begin
      case (sh)
        2'd0:    storev = s;
        2'd1:    storev = {s[23:0], d[7:0]};
        2'd2:    storev = {s[15:0], d[15:0]};
        default: storev = {s[7:0], d[23:0]};
      endcase
    end
  end

  always_comb begin
    res      = '0;
    arch_nxt = arch;
    md.start = 1'b0;
    md.op    = mieu_pkg::MD_MULT;
    md.a     = a;
    md.b     = b;
    wreq     = 1'b0;
    widx     = rd;
    wval     = 32'd0;

    if (item.kind) begin
      if (arch.pend_kind != mieu_pkg::PK_NONE) begin
        arch_nxt.pend_kind = mieu_pkg::PK_NONE;
        case (arch.pend_kind)
          mieu_pkg::PK_SWL, mieu_pkg::PK_SWR: begin
            res.mem_op    = mieu_pkg::MEM_WR_WORD;
            res.mem_addr  = {arch.pend_addr[31:2], 2'b00};
            res.mem_wdata = storev;
          end
          default: begin
            wreq                   = 1'b1;
            widx                   = tgt;
            wval                   = loadv;
            arch_nxt.load_issued   = 1'b1;
            arch_nxt.delayed_index = tgt;
            arch_nxt.delayed_old   = old;
          end
        endcase
      end
    end else begin
      arch_nxt.delay_active = arch.load_issued;
      arch_nxt.load_issued  = 1'b0;
      arch_nxt.pend_kind    = mieu_pkg::PK_NONE;
      case (opc)
        mieu_pkg::OP_SPECIAL: begin
          case (fn)
            mieu_pkg::FN_SLL:  begin wreq = 1'b1; wval = b << sa; end
            mieu_pkg::FN_SRL:  begin wreq = 1'b1; wval = b >> sa; end
            mieu_pkg::FN_SRA:  begin wreq = 1'b1; wval = 32'($signed(b) >>> sa); end
            mieu_pkg::FN_SLLV: begin wreq = 1'b1; wval = b << a[4:0]; end
            mieu_pkg::FN_SRLV: begin wreq = 1'b1; wval = b >> a[4:0]; end
            mieu_pkg::FN_SRAV: begin wreq = 1'b1; wval = 32'($signed(b) >>> a[4:0]); end
            mieu_pkg::FN_JR: begin
              res.branch_taken  = 1'b1;
              res.branch_target = a;
            end
            mieu_pkg::FN_JALR: begin
              res.branch_taken  = 1'b1;
              res.branch_target = a;
              wreq              = 1'b1;
              wval              = item.link_pc;
            end
            mieu_pkg::FN_SYSCALL: res.exception_code = mieu_pkg::EXC_SYSCALL;
            mieu_pkg::FN_BREAK:   res.exception_code = mieu_pkg::EXC_BREAK;
            mieu_pkg::FN_MFHI: begin wreq = 1'b1; wval = arch.hi; end
            mieu_pkg::FN_MTHI: arch_nxt.hi = a;
            mieu_pkg::FN_MFLO: begin wreq = 1'b1; wval = arch.lo; end
            mieu_pkg::FN_MTLO: arch_nxt.lo = a;
            mieu_pkg::FN_MULT: begin md.start = 1'b1; md.op = mieu_pkg::MD_MULT; end
            mieu_pkg::FN_MULTU: begin md.start = 1'b1; md.op = mieu_pkg::MD_MULTU; end
            mieu_pkg::FN_DIV:  begin md.start = 1'b1; md.op = mieu_pkg::MD_DIV; end
            mieu_pkg::FN_DIVU: begin md.start = 1'b1; md.op = mieu_pkg::MD_DIVU; end
            mieu_pkg::FN_ADD: begin
              if (~(a[31] ^ b[31]) & (a[31] ^ sum[31])) begin
                res.exception_code = mieu_pkg::EXC_OVERFLOW;
              end else begin
                wreq = 1'b1;
                wval = sum;
              end
            end
            mieu_pkg::FN_ADDU: begin wreq = 1'b1; wval = sum; end
            mieu_pkg::FN_SUB: begin
              if ((a[31] ^ b[31]) & (a[31] ^ dif[31])) begin
                res.exception_code = mieu_pkg::EXC_OVERFLOW;
              end else begin
                wreq = 1'b1;
                wval = dif;
              end
            end
            mieu_pkg::FN_SUBU: begin wreq = 1'b1; wval = dif; end
            mieu_pkg::FN_AND:  begin wreq = 1'b1; wval = a & b; end
            mieu_pkg::FN_OR:   begin wreq = 1'b1; wval = a | b; end
            mieu_pkg::FN_XOR:  begin wreq = 1'b1; wval = a ^ b; end
            mieu_pkg::FN_NOR:  begin wreq = 1'b1; wval = ~(a | b); end
            mieu_pkg::FN_SLT: begin
              wreq = 1'b1;
              wval = {31'd0, $signed(a) < $signed(b)};
            end
            mieu_pkg::FN_SLTU: begin wreq = 1'b1; wval = {31'd0, a < b}; end
            default: res.exception_code = mieu_pkg::EXC_RESERVED;
          endcase
        end
        mieu_pkg::OP_REGIMM: begin
          // link happens whether or not the branch goes
          if (item.instruction[20:17] == mieu_pkg::REGIMM_LINK) begin
            wreq = 1'b1;
            widx = mieu_pkg::LINK_REG;
            wval = item.link_pc;
          end
          if (item.instruction[16] ? !a[31] : a[31]) begin
            res.branch_taken  = 1'b1;
            res.branch_target = btgt;
          end
        end
        mieu_pkg::OP_J: begin
          res.branch_taken  = 1'b1;
          res.branch_target = jtgt;
        end
        mieu_pkg::OP_JAL: begin
          res.branch_taken  = 1'b1;
          res.branch_target = jtgt;
          wreq              = 1'b1;
          widx              = mieu_pkg::LINK_REG;
          wval              = item.link_pc;
        end
        mieu_pkg::OP_BEQ: begin
          res.branch_taken  = (a == b);
          res.branch_target = (a == b) ? btgt : 32'd0;
        end
        mieu_pkg::OP_BNE: begin
          res.branch_taken  = (a != b);
          res.branch_target = (a != b) ? btgt : 32'd0;
        end
        mieu_pkg::OP_BLEZ: begin
          res.branch_taken  = a[31] || (a == 32'd0);
          res.branch_target = (a[31] || (a == 32'd0)) ? btgt : 32'd0;
        end
        mieu_pkg::OP_BGTZ: begin
          res.branch_taken  = !a[31] && (a != 32'd0);
          res.branch_target = (!a[31] && (a != 32'd0)) ? btgt : 32'd0;
        end
        mieu_pkg::OP_ADDI: begin
          widx = rt;
          if (~(a[31] ^ simm[31]) & (a[31] ^ ad[31])) begin
            res.exception_code = mieu_pkg::EXC_OVERFLOW;
          end else begin
            wreq = 1'b1;
            wval = ad;
          end
        end
        mieu_pkg::OP_ADDIU: begin widx = rt; wreq = 1'b1; wval = ad; end
        mieu_pkg::OP_SLTI: begin
          widx = rt;
          wreq = 1'b1;
          wval = {31'd0, $signed(a) < $signed(simm)};
        end
        mieu_pkg::OP_SLTIU: begin widx = rt; wreq = 1'b1; wval = {31'd0, a < simm}; end
        mieu_pkg::OP_ANDI:  begin widx = rt; wreq = 1'b1; wval = a & zimm; end
        mieu_pkg::OP_ORI:   begin widx = rt; wreq = 1'b1; wval = a | zimm; end
        mieu_pkg::OP_XORI:  begin widx = rt; wreq = 1'b1; wval = a ^ zimm; end
        mieu_pkg::OP_LUI:   begin widx = rt; wreq = 1'b1; wval = {imm, 16'd0}; end
        mieu_pkg::OP_COP0, mieu_pkg::OP_COP1, mieu_pkg::OP_COP2, mieu_pkg::OP_COP3,
        mieu_pkg::OP_LWC0, mieu_pkg::OP_LWC1, mieu_pkg::OP_LWC2, mieu_pkg::OP_LWC3,
        mieu_pkg::OP_SWC0, mieu_pkg::OP_SWC1, mieu_pkg::OP_SWC2, mieu_pkg::OP_SWC3:
          res.exception_code = mieu_pkg::EXC_COP;
        mieu_pkg::OP_LB, mieu_pkg::OP_LBU: begin
          arch_nxt.pend_kind   = (opc == mieu_pkg::OP_LB) ? mieu_pkg::PK_LB : mieu_pkg::PK_LBU;
          arch_nxt.pend_target = rt;
          arch_nxt.pend_addr   = ad;
          arch_nxt.pend_store  = 32'd0;
          res.mem_op           = mieu_pkg::MEM_RD_BYTE;
          res.mem_addr         = ad;
        end
        mieu_pkg::OP_LH, mieu_pkg::OP_LHU: begin
          if (ad[0]) begin
            res.exception_code = mieu_pkg::EXC_LOAD_ADDR;
          end else begin
            arch_nxt.pend_kind   = (opc == mieu_pkg::OP_LH) ? mieu_pkg::PK_LH : mieu_pkg::PK_LHU;
            arch_nxt.pend_target = rt;
            arch_nxt.pend_addr   = ad;
            arch_nxt.pend_store  = 32'd0;
            res.mem_op           = mieu_pkg::MEM_RD_HALF;
            res.mem_addr         = ad;
          end
        end
        mieu_pkg::OP_LW: begin
          if (ad[1:0] != 2'd0) begin
            res.exception_code = mieu_pkg::EXC_LOAD_ADDR;
          end else begin
            arch_nxt.pend_kind   = mieu_pkg::PK_LW;
            arch_nxt.pend_target = rt;
            arch_nxt.pend_addr   = ad;
            arch_nxt.pend_store  = 32'd0;
            res.mem_op           = mieu_pkg::MEM_RD_WORD;
            res.mem_addr         = ad;
          end
        end
        mieu_pkg::OP_LWL, mieu_pkg::OP_LWR, mieu_pkg::OP_SWL, mieu_pkg::OP_SWR: begin
          // partial-word access: read the aligned word, merge on return
          case (opc)
            mieu_pkg::OP_LWL: arch_nxt.pend_kind = mieu_pkg::PK_LWL;
            mieu_pkg::OP_LWR: arch_nxt.pend_kind = mieu_pkg::PK_LWR;
            mieu_pkg::OP_SWL: arch_nxt.pend_kind = mieu_pkg::PK_SWL;
            default:          arch_nxt.pend_kind = mieu_pkg::PK_SWR;
          endcase
          arch_nxt.pend_target = rt;
          arch_nxt.pend_addr   = ad;
          arch_nxt.pend_store  = (opc == mieu_pkg::OP_SWL || opc == mieu_pkg::OP_SWR) ?
                                 b : 32'd0;
          res.mem_op           = mieu_pkg::MEM_RD_WORD;
          res.mem_addr         = {ad[31:2], 2'b00};
        end
        mieu_pkg::OP_SB: begin
          res.mem_op    = mieu_pkg::MEM_WR_BYTE;
          res.mem_addr  = ad;
          res.mem_wdata = {24'd0, b[7:0]};
        end
        mieu_pkg::OP_SH: begin
          if (ad[0]) begin
            res.exception_code = mieu_pkg::EXC_STORE_ADDR;
          end else begin
            res.mem_op    = mieu_pkg::MEM_WR_HALF;
            res.mem_addr  = ad;
            res.mem_wdata = {16'd0, b[15:0]};
          end
        end
        mieu_pkg::OP_SW: begin
          if (ad[1:0] != 2'd0) begin
            res.exception_code = mieu_pkg::EXC_STORE_ADDR;
          end else begin
            res.mem_op    = mieu_pkg::MEM_WR_WORD;
            res.mem_addr  = ad;
            res.mem_wdata = b;
          end
        end
        default: res.exception_code = mieu_pkg::EXC_RESERVED;
      endcase
    end

    // r0 is never written or reported
    wr.en        = wreq && (widx != 5'd0);
    wr.idx       = widx;
    wr.data      = wval;
    res.wb_valid = wr.en;
    res.wb_index = wr.en ? widx : 5'd0;
    res.wb_value = wr.en ? wval : 32'd0;
  end

endmodule
